// File: design/vpc_pkg.sv
package vpc_pkg;

	// Default number of translation entries (cells in the chain)
	localparam int unsigned ENTRIES_DEF = 64;

	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned PAGE_W   = ADDR_W - OFFSET_W;

	// Request codes
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_FLUSH  = 2'd3
	} req_op_t;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_SKIP = 2'd3;

	// Request held steady and broadcast to every cell during a walk
	typedef struct packed {
		req_op_t             op;
		logic                flush_all;
		logic [ADDR_W-1:0]   tb;
		logic [ADDR_W-1:0]   nb;
		logic [PAGE_W-1:0]   vp;
		logic [PAGE_W-1:0]   pp;
	} req_t;

	// Token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic              active;
		logic              hit;
		logic [PAGE_W-1:0] pp;
		logic              free_found;
	} tok_t;

endpackage

// File: design/vpc_cell.sv
module vpc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  vpc_pkg::req_t req,
	input  vpc_pkg::tok_t tok_in,
	input  logic          wr_en,
	output vpc_pkg::tok_t tok_out
);

	logic                        valid_q;
	logic                        cand_q;
	logic [vpc_pkg::ADDR_W-1:0]  tb_q;
	logic [vpc_pkg::ADDR_W-1:0]  nb_q;
	logic [vpc_pkg::PAGE_W-1:0]  vp_q;
	logic [vpc_pkg::PAGE_W-1:0]  pp_q;
	vpc_pkg::tok_t               tok_q;
	vpc_pkg::tok_t               tok_nxt;
	logic                        as_match;
	logic                        key_match;
	logic                        take_free;

	// Key compare against the broadcast request
	assign as_match  = valid_q && (tb_q == req.tb) && (nb_q == req.nb);
	assign key_match = as_match && (vp_q == req.vp);
	assign take_free = (req.op == vpc_pkg::REQ_INSERT) && !valid_q && !tok_in.free_found;

	// Token update as it passes this cell
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.active) begin
			case (req.op)
				vpc_pkg::REQ_LOOKUP: begin
					if (key_match && !tok_in.hit) begin
						tok_nxt.hit = 1'b1;
						tok_nxt.pp  = pp_q;
					end
				end
				vpc_pkg::REQ_INSERT: begin
					if (key_match) tok_nxt.hit = 1'b1;
					if (take_free) tok_nxt.free_found = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Valid bit and first-free marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
		end else begin
			if (tok_in.active) cand_q <= take_free;
			if (wr_en && cand_q) begin
				valid_q <= 1'b1;
			end else if (tok_in.active) begin
				if (req.op == vpc_pkg::REQ_DELETE && key_match) valid_q <= 1'b0;
				if (req.op == vpc_pkg::REQ_FLUSH && (req.flush_all || as_match))
					valid_q <= 1'b0;
			end
		end
	end

	// Entry payload: overwrite the physical page in place on an insert key hit, fill when claimed
	always_ff @(posedge clk) begin
		if (wr_en && cand_q) begin
			tb_q <= req.tb;
			nb_q <= req.nb;
			vp_q <= req.vp;
			pp_q <= req.pp;
		end else if (tok_in.active && req.op == vpc_pkg::REQ_INSERT && key_match) begin
			pp_q <= req.pp;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: design/virtual_to_physical_page_cache_top.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, virt_addr, table_base, nested_base, phys_addr_in
// out       out_valid / out_ready  status, phys_addr_out
// cfg       cfg_valid / cfg_ready  safety_checks
//
// One item at a time: a request token walks the cell chain, one cell per cycle.
// A skipped insert does not walk the chain and goes straight to the final state.
// An insert that misses claims the first free cell in the cycle the token leaves the chain.
// Reset clears all valid bits and the safety check register at once; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile, and a
// finished item stalls in the final state until the output register frees.
module virtual_to_physical_page_cache_top #(
	parameter int unsigned ENTRIES = vpc_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic [vpc_pkg::ADDR_W-1:0] virt_addr,
	input  logic [vpc_pkg::ADDR_W-1:0] table_base,
	input  logic [vpc_pkg::ADDR_W-1:0] nested_base,
	input  logic [vpc_pkg::ADDR_W-1:0] phys_addr_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [vpc_pkg::ADDR_W-1:0] phys_addr_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       safety_checks
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                             state_q;
	logic                               safety_q;
	logic                               launch_q;
	vpc_pkg::req_t                      req_q;
	logic [vpc_pkg::OFFSET_W-1:0]       off_q;
	logic [1:0]                         res_status_q;
	logic [vpc_pkg::ADDR_W-1:0]         res_phys_q;
	logic                               out_valid_q;
	logic [1:0]                         out_status_q;
	logic [vpc_pkg::ADDR_W-1:0]         out_phys_q;
	vpc_pkg::tok_t                      tok_head;
	vpc_pkg::tok_t                      tok_chain [ENTRIES+1];
	vpc_pkg::tok_t                      tok_end;
	logic                               in_fire;
	logic                               skip;
	logic                               wr_en;
	logic                               out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// Safety check on the full addresses
	assign skip = safety_q && (vpc_pkg::req_op_t'(req_type) == vpc_pkg::REQ_INSERT) &&
		((virt_addr == '0) || (table_base == '0) || (phys_addr_in == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safety_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			safety_q <= safety_checks;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q.op        <= vpc_pkg::req_op_t'(req_type);
			req_q.flush_all <= (table_base == '1);
			req_q.tb        <= table_base;
			req_q.nb        <= nested_base;
			req_q.vp        <= virt_addr[vpc_pkg::ADDR_W-1:vpc_pkg::OFFSET_W];
			req_q.pp        <= phys_addr_in[vpc_pkg::ADDR_W-1:vpc_pkg::OFFSET_W];
			off_q           <= virt_addr[vpc_pkg::OFFSET_W-1:0];
		end
	end

	// Cell chain
	always_comb begin
		tok_head        = '0;
		tok_head.active = launch_q;
	end

	assign tok_chain[0] = tok_head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		vpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_q),
			.tok_in  (tok_chain[i]),
			.wr_en   (wr_en),
			.tok_out (tok_chain[i+1])
		);
	end

	assign tok_end = tok_chain[ENTRIES];
	assign wr_en   = tok_end.active && (req_q.op == vpc_pkg::REQ_INSERT) &&
		!tok_end.hit && tok_end.free_found;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= in_fire && !skip;
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= skip ? ST_FIN : ST_WALK;
				ST_WALK: if (tok_end.active) state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result formation
	always_ff @(posedge clk) begin
		if (in_fire && skip) begin
			res_status_q <= vpc_pkg::ST_SKIP;
			res_phys_q   <= '0;
		end else if (tok_end.active) begin
			res_status_q <= vpc_pkg::ST_OK;
			res_phys_q   <= '0;
			case (req_q.op)
				vpc_pkg::REQ_LOOKUP: begin
					if (tok_end.hit) res_phys_q <= {tok_end.pp, off_q};
					else res_status_q <= vpc_pkg::ST_MISS;
				end
				vpc_pkg::REQ_INSERT: begin
					if (!tok_end.hit && !tok_end.free_found) res_status_q <= vpc_pkg::ST_FULL;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_phys_q   <= res_phys_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign phys_addr_out = out_phys_q;

	// Checks
	a_end_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.active |-> (state_q == ST_WALK))
		else $error("token left the chain outside a walk");

	a_launch_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> (state_q == ST_WALK))
		else $error("token launched outside a walk");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (res_status_q != vpc_pkg::ST_OK)) |-> (res_phys_q == '0))
		else $error("nonzero address with a failing status");

endmodule
